/* src/trrs_pkg.sv */
// package for the time range render scheduler: sizes, codes and types
package trrs_pkg;

  localparam int unsigned MAX_RANGES = 16;
  localparam int unsigned IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_RANGES + 1);

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_DRAWN = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    TYPE_ONCE       = 2'd0,
    TYPE_CONTINUOUS = 2'd1,
    TYPE_NONE       = 2'd2,
    TYPE_UNUSED     = 2'd3
  } range_type_e;

  // one stored range
  typedef struct packed {
    logic signed [31:0] start;
    logic [1:0]         rtype;
    logic               upd;
  } entry_t;

  // per-cell control from the top level
  typedef struct packed {
    logic ins;  // an add is being written this cycle
    logic occ;  // cell holds a live range
  } cell_ctl_t;

endpackage

/* src/trrs_if.sv */
// handshake channels for command words and result words
interface trrs_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] time_value;
  logic [1:0]         range_type;
  logic               update_flag;

  modport source (output valid, cmd, time_value, range_type, update_flag, input ready);
  modport sink   (input valid, cmd, time_value, range_type, update_flag, output ready);
endinterface

interface trrs_rsp_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [3:0] range_index;
  logic       active_bit;
  logic       prefetch_bit;
  logic       need_clean;
  logic       status;

  modport source (output valid, found, range_index, active_bit, prefetch_bit, need_clean,
                  status, input ready);
  modport sink   (input valid, found, range_index, active_bit, prefetch_bit, need_clean,
                  status, output ready);
endinterface

/* src/time_range_render_scheduler.sv */
// top level of the time range render scheduler: cell chain, draw record, result register
// the result word is registered: it is valid in the cycle after its command word is accepted
// throughput: one command word per cycle while results are taken; every cell compares and shifts in that cycle
// a new command is taken while the result register is empty or being emptied
// reset: range count, draw record and result valid clear; stored ranges are left as is
module time_range_render_scheduler (
  input  logic          clk_i,
  input  logic          rst_ni,
  trrs_req_if.sink      req_i,
  trrs_rsp_if.source    rsp_o
);

  localparam int unsigned N = trrs_pkg::MAX_RANGES;

  // chain wiring
  trrs_pkg::entry_t    entry [N];
  trrs_pkg::entry_t    prev  [N];
  trrs_pkg::cell_ctl_t ctl   [N];
  logic [N-1:0]        le;
  logic [N-1:0]        le_prev;
  logic [N-1:0]        hit;     // last cell at or before the time
  logic [N-1:0]        is_last; // last live cell

  logic [trrs_pkg::CNT_W-1:0] count_q, count_d;
  logic [trrs_pkg::IDX_W-1:0] drawn_idx_q, drawn_idx_d;
  logic                       drawn_vld_q, drawn_vld_d;

  logic       rsp_vld_q;
  logic       found_q, found_d;
  logic [3:0] index_q, index_d;
  logic       active_q, active_d;
  logic       prefetch_q, prefetch_d;
  logic       clean_q, clean_d;
  logic       status_q, status_d;

  logic accept;
  logic full;
  logic do_insert;
  trrs_pkg::entry_t new_entry;

  // hit-side selections
  logic [trrs_pkg::IDX_W-1:0] hit_idx;
  logic [3:0]                 hit_idx4;
  logic [1:0]                 hit_type;
  logic                       hit_upd;
  logic                       hit_last;
  logic                       hit_drawn;

  assign req_i.ready = !rsp_vld_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (count_q >= trrs_pkg::CNT_W'(N));
  assign do_insert   = accept && (trrs_pkg::cmd_e'(req_i.cmd) == trrs_pkg::CMD_ADD) && !full;

  assign new_entry.start = req_i.time_value;
  assign new_entry.rtype = req_i.range_type;
  assign new_entry.upd   = req_i.update_flag;

  // cell i takes the new range when it sits just past the last start <= time,
  // otherwise it takes its left neighbor's range if it is past that point
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign le_prev[i] = 1'b1;
      assign prev[i]    = new_entry;
    end else begin : g_body
      assign le_prev[i] = le[i-1];
      assign prev[i]    = entry[i-1];
    end

    assign ctl[i].ins = do_insert;
    assign ctl[i].occ = (trrs_pkg::CNT_W'(i) < count_q);

    if (i == N - 1) begin : g_tail
      assign hit[i]     = le[i];
      assign is_last[i] = ctl[i].occ;
    end else begin : g_mid
      assign hit[i]     = le[i] && !le[i+1];
      assign is_last[i] = ctl[i].occ && !ctl[i+1].occ;
    end

    trrs_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl[i]),
      .time_i    (req_i.time_value),
      .new_i     (new_entry),
      .prev_i    (prev[i]),
      .le_prev_i (le_prev[i]),
      .entry_o   (entry[i]),
      .le_o      (le[i])
    );
  end

  // one-hot hit turned into index and selected fields
  always_comb begin
    hit_idx  = '0;
    hit_idx4 = '0;
    hit_type = '0;
    hit_upd  = 1'b0;
    hit_last = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (hit[i]) begin
        hit_idx  = hit_idx  | trrs_pkg::IDX_W'(i);
        hit_idx4 = hit_idx4 | 4'(i);
        hit_type = hit_type | entry[i].rtype;
        hit_upd  = hit_upd  | entry[i].upd;
        hit_last = hit_last | is_last[i];
      end
    end
  end

  assign hit_drawn = drawn_vld_q && hit[drawn_idx_q];

  // state updates and result word
  always_comb begin
    count_d     = count_q;
    drawn_idx_d = drawn_idx_q;
    drawn_vld_d = drawn_vld_q;
    found_d     = 1'b0;
    index_d     = '0;
    active_d    = 1'b0;
    prefetch_d  = 1'b0;
    clean_d     = 1'b0;
    status_d    = 1'b0;
    case (trrs_pkg::cmd_e'(req_i.cmd))
      trrs_pkg::CMD_ADD: begin
        if (full) begin
          status_d = 1'b1;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      trrs_pkg::CMD_QUERY: begin
        if (le[0]) begin
          found_d = 1'b1;
          index_d = hit_idx4;
          if (trrs_pkg::range_type_e'(hit_type) == trrs_pkg::TYPE_CONTINUOUS) begin
            active_d   = 1'b1;
            prefetch_d = 1'b1;
          end else begin
            prefetch_d = hit_upd && !hit_last;
            active_d   = (trrs_pkg::range_type_e'(hit_type) == trrs_pkg::TYPE_ONCE)
                         && !hit_drawn;
            clean_d    = hit_last && hit_drawn;
          end
        end
      end
      trrs_pkg::CMD_DRAWN: begin
        if (le[0]) begin
          found_d     = 1'b1;
          index_d     = hit_idx4;
          drawn_idx_d = hit_idx;
          drawn_vld_d = 1'b1;
        end else begin
          drawn_idx_d = '0;
          drawn_vld_d = 1'b0;
        end
      end
      trrs_pkg::CMD_CLEAR: begin
        drawn_idx_d = '0;
        drawn_vld_d = 1'b0;
      end
      default: begin
        status_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drawn_idx_q <= '0;
      drawn_vld_q <= 1'b0;
      rsp_vld_q   <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        drawn_idx_q <= drawn_idx_d;
        drawn_vld_q <= drawn_vld_d;
        rsp_vld_q   <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted command
  always_ff @(posedge clk_i) begin
    if (accept) begin
      found_q    <= found_d;
      index_q    <= index_d;
      active_q   <= active_d;
      prefetch_q <= prefetch_d;
      clean_q    <= clean_d;
      status_q   <= status_d;
    end
  end

  assign rsp_o.valid        = rsp_vld_q;
  assign rsp_o.found        = found_q;
  assign rsp_o.range_index  = index_q;
  assign rsp_o.active_bit   = active_q;
  assign rsp_o.prefetch_bit = prefetch_q;
  assign rsp_o.need_clean   = clean_q;
  assign rsp_o.status       = status_q;

endmodule

/* src/trrs_cell.sv */
// one slot of the sorted range chain: compare against time, hold or shift on insert
module trrs_cell (
  input  logic               clk_i,
  input  trrs_pkg::cell_ctl_t ctl_i,
  input  logic signed [31:0] time_i,
  input  trrs_pkg::entry_t   new_i,
  input  trrs_pkg::entry_t   prev_i,
  input  logic               le_prev_i,
  output trrs_pkg::entry_t   entry_o,
  output logic               le_o
);

  trrs_pkg::entry_t entry_q, entry_d;

  // live range that starts at or before the given time
  assign le_o    = ctl_i.occ && (entry_q.start <= time_i);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins && !le_o) begin
      if (le_prev_i) begin
        entry_d = new_i;
      end else begin
        entry_d = prev_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* tb/sv/tb_time_range_render_scheduler.sv */
// self-checking testbench for the time range render scheduler: directed rows, then random traffic
module tb_time_range_render_scheduler;
  import trrs_pkg::*;

  localparam int unsigned HALF_PERIOD    = 6;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned RANDOM_WORDS   = 1200;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned MAX_REPORTS    = 10;

  localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;

  // one result word as the block answers it
  typedef struct packed {
    logic       found;
    logic [3:0] range_index;
    logic       active_bit;
    logic       prefetch_bit;
    logic       need_clean;
    logic       status;
  } sched_result_t;

  // one row of the directed part; a typed-in answer is used where has_answer is set
  typedef struct {
    cmd_e               cmd;
    logic signed [31:0] t;
    range_type_e        rtype;
    logic               upd;
    bit                 has_answer;
    sched_result_t      answer;
  } stim_row_t;

  // typed-in answer travelling alongside a command word until it is accepted
  typedef struct {
    bit            has_answer;
    sched_result_t answer;
  } typed_note_t;

  logic clk_i;
  logic rst_ni;

  trrs_req_if req_if ();
  trrs_rsp_if rsp_if ();

  time_range_render_scheduler DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // shadow copy of the range table, kept in step with every accepted command
  logic signed [31:0] shadow_start [MAX_RANGES];
  range_type_e        shadow_type  [MAX_RANGES];
  logic               shadow_upd   [MAX_RANGES];
  int unsigned        shadow_count;
  logic [IDX_W-1:0]   shadow_drawn_idx;
  bit                 shadow_drawn_vld;

  sched_result_t pending_results [$];
  typed_note_t   typed_notes     [$];
  stim_row_t     stim_rows       [$];

  bit no_idle;
  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned n_add, n_refused, n_query, n_drawn, n_clear, n_found;
  int unsigned n_clean, n_active, n_prefetch;

  // number of stored ranges that start at or before t
  function automatic int unsigned ranges_not_after(logic signed [31:0] t);
    int unsigned n;
    int unsigned i;
    n = 0;
    for (i = 0; i < shadow_count; i++) begin
      if (t < shadow_start[i]) break;
      n = i + 1;
    end
    return n;
  endfunction

  // works out the answer to one command and updates the shadow state
  function automatic sched_result_t schedule_step(cmd_e c, logic signed [31:0] t,
                                                  range_type_e rt, logic u);
    sched_result_t r;
    int unsigned   n;
    int unsigned   i;
    int unsigned   idx;
    bit            last;
    bit            is_drawn;
    r = '0;
    case (c)
      CMD_ADD: begin
        if (shadow_count >= MAX_RANGES) begin
          // table full: nothing stored
          r.status = 1'b1;
        end else begin
          // new range goes after every range with an equal or earlier start
          n = ranges_not_after(t);
          for (i = shadow_count; i > n; i--) begin
            shadow_start[i] = shadow_start[i-1];
            shadow_type[i]  = shadow_type[i-1];
            shadow_upd[i]   = shadow_upd[i-1];
          end
          shadow_start[n] = t;
          shadow_type[n]  = rt;
          shadow_upd[n]   = u;
          shadow_count++;
        end
      end
      CMD_CLEAR: begin
        shadow_drawn_vld = 1'b0;
        shadow_drawn_idx = '0;
      end
      default: begin
        n = ranges_not_after(t);
        if (n == 0) begin
          // nothing starts this early: a mark-drawn forgets the record
          if (c == CMD_DRAWN) begin
            shadow_drawn_vld = 1'b0;
            shadow_drawn_idx = '0;
          end
        end else begin
          idx           = n - 1;
          r.found       = 1'b1;
          r.range_index = idx[3:0];
          if (c == CMD_DRAWN) begin
            shadow_drawn_idx = idx[IDX_W-1:0];
            shadow_drawn_vld = 1'b1;
          end else begin
            last     = (idx == shadow_count - 1);
            is_drawn = shadow_drawn_vld && (shadow_drawn_idx == idx[IDX_W-1:0]);
            if (shadow_type[idx] == TYPE_CONTINUOUS) begin
              r.active_bit   = 1'b1;
              r.prefetch_bit = 1'b1;
            end else begin
              // the unused type code falls through as no render
              r.prefetch_bit = shadow_upd[idx] && !last;
              r.active_bit   = (shadow_type[idx] == TYPE_ONCE) && !is_drawn;
              r.need_clean   = last && is_drawn;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  // times near stored starts hit the interesting boundaries; the rest spread wide
  function automatic logic signed [31:0] pick_time();
    logic signed [31:0] base;
    base = (shadow_count > 0) ? shadow_start[$urandom_range(0, shadow_count - 1)] : 32'sd0;
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return T_MIN;
      3:       return T_MAX;
      4:       return base - 32'sd1;
      5:       return base + 32'sd1;
      6:       return base + $signed({16'h0, 16'($urandom)});
      default: return base;
    endcase
  endfunction

  function automatic stim_row_t mk_row(cmd_e c, logic signed [31:0] t, range_type_e rt,
                                       logic u, bit has, sched_result_t ans);
    stim_row_t s;
    s.cmd        = c;
    s.t          = t;
    s.rtype      = rt;
    s.upd        = u;
    s.has_answer = has;
    s.answer     = ans;
    return s;
  endfunction

  // appends one row to the directed table
  function automatic void queue_row(stim_row_t s);
    stim_rows.insert(stim_rows.size(), s);
  endfunction

  // drives one command word and holds it until the block takes it
  task automatic put_word(cmd_e c, logic signed [31:0] t, range_type_e rt, logic u,
                          bit has, sched_result_t ans);
    int unsigned gap;
    typed_note_t note;
    gap = draw_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    note.has_answer = has;
    note.answer     = ans;
    typed_notes.insert(typed_notes.size(), note);
    req_if.valid       <= 1'b1;
    req_if.cmd         <= c;
    req_if.time_value  <= t;
    req_if.range_type  <= rt;
    req_if.update_flag <= u;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // result side back-pressure: a fresh stall is drawn after every result word
  int unsigned rsp_gap;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_gap = 0;
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) rsp_gap = draw_gap();
      else if (rsp_gap > 0) rsp_gap--;
      rsp_if.ready <= (rsp_gap == 0);
    end
  end

  // predict on every accepted command word, check every accepted result word
  always @(posedge clk_i) begin
    sched_result_t want;
    sched_result_t got;
    typed_note_t   note;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{rsp_if.found, rsp_if.range_index, rsp_if.active_bit, rsp_if.prefetch_bit,
                rsp_if.need_clean, rsp_if.status};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] result word with nothing pending: %p", $realtime, got);
        end else begin
          want = pending_results.pop_front();
          words_checked++;
          if (got.found !== want.found || got.range_index !== want.range_index ||
              got.active_bit !== want.active_bit || got.prefetch_bit !== want.prefetch_bit ||
              got.need_clean !== want.need_clean || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("[%0t] mismatch: expected %p, got %p", $realtime, want, got);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        want = schedule_step(cmd_e'(req_if.cmd), req_if.time_value,
                             range_type_e'(req_if.range_type), req_if.update_flag);
        note = typed_notes.pop_front();
        case (cmd_e'(req_if.cmd))
          CMD_ADD:   begin n_add++; if (want.status) n_refused++; end
          CMD_QUERY: n_query++;
          CMD_DRAWN: n_drawn++;
          default:   n_clear++;
        endcase
        if (want.found) n_found++;
        if (want.need_clean) n_clean++;
        if (want.active_bit) n_active++;
        if (want.prefetch_bit) n_prefetch++;
        pending_results.insert(pending_results.size(), note.has_answer ? note.answer : want);
      end
    end
  end

  // watchdog: ends the run if neither side moves a word for too long
  initial begin
    int unsigned idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle = 0;
      else idle++;
    end
    $display("watchdog: no word moved for %0d cycles, %0d results pending",
             WATCHDOG_LIMIT, pending_results.size());
    $display("tb_time_range_render_scheduler: FAIL");
    $finish;
  end

  initial begin
    int unsigned k;
    int unsigned pick;
    cmd_e        c;
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.cmd         = CMD_QUERY;
    req_if.time_value  = '0;
    req_if.range_type  = TYPE_ONCE;
    req_if.update_flag = 1'b0;
    rsp_if.ready       = 1'b0;
    no_idle            = 1'b0;
    mismatches         = 0;
    words_checked      = 0;
    shadow_count       = 0;
    shadow_drawn_idx   = '0;
    shadow_drawn_vld   = 1'b0;

    // directed part
    // empty table: query, mark-drawn and clear all answer zero
    queue_row(mk_row(CMD_QUERY, 32'sd0, TYPE_ONCE, 1'b0, 1'b1, '0));
    queue_row(mk_row(CMD_DRAWN, T_MAX, TYPE_ONCE, 1'b0, 1'b1, '0));
    queue_row(mk_row(CMD_CLEAR, T_MIN, TYPE_ONCE, 1'b0, 1'b1, '0));
    // adds at both extremes, all four type codes, two equal starts
    queue_row(mk_row(CMD_ADD, T_MIN, TYPE_ONCE, 1'b1, 1'b1, '0));
    queue_row(mk_row(CMD_ADD, T_MAX, TYPE_CONTINUOUS, 1'b0, 1'b1, '0));
    queue_row(mk_row(CMD_ADD, 32'sd0, TYPE_NONE, 1'b1, 1'b1, '0));
    queue_row(mk_row(CMD_ADD, 32'sd0, TYPE_UNUSED, 1'b1, 1'b1, '0));
    // lookups across the table, the unused type acting as no render
    queue_row(mk_row(CMD_QUERY, T_MIN, TYPE_ONCE, 1'b0, 1'b0, '0));
    queue_row(mk_row(CMD_QUERY, -32'sd1, TYPE_ONCE, 1'b0, 1'b0, '0));
    queue_row(mk_row(CMD_QUERY, 32'sd0, TYPE_ONCE, 1'b0, 1'b0, '0));
    queue_row(mk_row(CMD_QUERY, T_MAX, TYPE_ONCE, 1'b0, 1'b0, '0));
    // a drawn render-once range stops being active
    queue_row(mk_row(CMD_DRAWN, T_MIN, TYPE_ONCE, 1'b0, 1'b0, '0));
    queue_row(mk_row(CMD_QUERY, T_MIN, TYPE_ONCE, 1'b0, 1'b0, '0));
    // continuous range stays active even when drawn
    queue_row(mk_row(CMD_DRAWN, T_MAX, TYPE_ONCE, 1'b0, 1'b0, '0));
    queue_row(mk_row(CMD_QUERY, T_MAX, TYPE_ONCE, 1'b0, 1'b0, '0));
    // last range drawn: need-clean, no prefetch
    queue_row(mk_row(CMD_ADD, T_MAX, TYPE_ONCE, 1'b1, 1'b1, '0));
    queue_row(mk_row(CMD_DRAWN, T_MAX, TYPE_ONCE, 1'b0, 1'b0, '0));
    queue_row(mk_row(CMD_QUERY, T_MAX, TYPE_ONCE, 1'b0, 1'b0, '0));
    // insert in front of the drawn range: the record keeps its old index
    queue_row(mk_row(CMD_ADD, T_MIN, TYPE_NONE, 1'b0, 1'b1, '0));
    queue_row(mk_row(CMD_QUERY, T_MAX, TYPE_ONCE, 1'b0, 1'b0, '0));
    queue_row(mk_row(CMD_QUERY, 32'sh7FFF_FFFE, TYPE_ONCE, 1'b0, 1'b0, '0));
    // clear forgets the record, ranges stay
    queue_row(mk_row(CMD_CLEAR, 32'sd0, TYPE_ONCE, 1'b0, 1'b1, '0));
    queue_row(mk_row(CMD_QUERY, T_MAX, TYPE_ONCE, 1'b0, 1'b0, '0));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i])
      put_word(stim_rows[i].cmd, stim_rows[i].t, stim_rows[i].rtype, stim_rows[i].upd,
               stim_rows[i].has_answer, stim_rows[i].answer);

    // random part: the table fills early, later adds are refused while lookups go on
    for (k = 0; k < RANDOM_WORDS; k++) begin
      // switch between stretches with and without idling
      if (k % 100 == 0) no_idle = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 25)      c = CMD_ADD;
      else if (pick < 70) c = CMD_QUERY;
      else if (pick < 90) c = CMD_DRAWN;
      else                c = CMD_CLEAR;
      put_word(c, (c == CMD_CLEAR && pick[0]) ? $urandom : pick_time(),
               range_type_e'($urandom_range(0, 3)), 1'($urandom), 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    // let the last accepted word be queued, then let the results come back
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d adds (%0d refused on a full table), %0d queries, %0d mark-drawn, %0d clears",
             n_add, n_refused, n_query, n_drawn, n_clear);
    $display("%0d results checked, %0d hits, %0d active, %0d prefetch, %0d need-clean",
             words_checked, n_found, n_active, n_prefetch, n_clean);
    if (mismatches == 0) begin
      $display("tb_time_range_render_scheduler: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_time_range_render_scheduler: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/trrs_pkg.sv
src/trrs_if.sv
src/trrs_cell.sv
src/time_range_render_scheduler.sv
tb/sv/tb_time_range_render_scheduler.sv
